// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the stack block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// types, codes and constants shared by the bounded stack block
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int DEF_STACK_DEPTH = 8;
    localparam int KIND_W          = 3;
    localparam int DATA_W          = 32;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISPLAY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MODIFY  = 3'd4;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DISP,
        S_SRCH
    } state_t;

    // stack read address source
    typedef enum logic [1:0] {
        RD_TOP,
        RD_ZERO,
        RD_IDX_DEC,
        RD_IDX_INC
    } rd_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    push_wr;
        logic    mod_wr;
        logic    fill_inc;
        logic    fill_dec;
        logic    idx_load_top;
        logic    idx_clear;
        logic    idx_dec;
        logic    idx_inc;
        logic    load_cmd;
        logic    emit;
        status_t emit_status;
        logic    emit_ram;
        logic    emit_last;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              empty;
        logic              idx_zero;
        logic              idx_top;
        logic              hit;
        logic              out_free;
    } dp_sts_t;

endpackage

// File: hdl/bss_if.sv
// ----------------------------------------------------------------------------
// bss_if
// valid/ready channels for stack commands and stack results
// ----------------------------------------------------------------------------
interface bss_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic signed [31:0] match_value;

    modport source (output valid, output kind, output value, output match_value,
                    input ready);
    modport sink   (input valid, input kind, input value, input match_value,
                    output ready);
endinterface

interface bss_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;

    modport source (output valid, output status, output data, output last,
                    input ready);
    modport sink   (input valid, input status, input data, input last,
                    output ready);
endinterface

// File: hdl/bss_ram.sv
// ----------------------------------------------------------------------------
// bss_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module bss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bss_dpath.sv
// ----------------------------------------------------------------------------
// bss_dpath
// stack datapath: entry RAM, fill count, walk index and result register
// ----------------------------------------------------------------------------
module bss_dpath
    import bss_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_sts_t            sts,
    input  logic [KIND_W-1:0]  in_kind,
    input  logic [DATA_W-1:0]  in_value,
    input  logic [DATA_W-1:0]  in_match_value,
    bss_res_if.source          res
);

    `include "assert_macros.svh"

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] value_reg, match_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [FILL_W-1:0] fill_m1;
    logic [ADDR_W-1:0] top_idx;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              out_free;

    assign fill_m1  = fill_count_reg - FILL_W'(1);
    assign top_idx  = fill_m1[ADDR_W-1:0];
    assign out_free = !out_valid_reg || res.ready;

    // status back to the controller
    always_comb
    begin
        sts.kind     = in_kind;
        sts.full     = (fill_count_reg == FILL_W'(STACK_DEPTH));
        sts.empty    = (fill_count_reg == '0);
        sts.idx_zero = (idx_reg == '0);
        sts.idx_top  = (idx_reg == top_idx);
        sts.hit      = (ram_rdata == match_reg);
        sts.out_free = out_free;
    end

    // entry write: push at the fill level, modify at the walk index
    always_comb
    begin
        ram_we    = cmd.push_wr || cmd.mod_wr;
        ram_waddr = cmd.push_wr ? fill_count_reg[ADDR_W-1:0] : idx_reg;
        ram_wdata = cmd.push_wr ? in_value : value_reg;
    end

    // entry read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_TOP:     ram_raddr = top_idx;
            RD_ZERO:    ram_raddr = '0;
            RD_IDX_DEC: ram_raddr = idx_reg - ADDR_W'(1);
            RD_IDX_INC: ram_raddr = idx_reg + ADDR_W'(1);
            default:    ram_raddr = top_idx;
        endcase
    end

    bss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fill count and walk index next values
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (cmd.fill_inc)
        begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_count_next = fill_m1;
        end

        idx_next = idx_reg;
        if (cmd.idx_load_top)
        begin
            idx_next = top_idx;
        end
        else if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - ADDR_W'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_cmd)
        begin
            value_reg <= in_value;
            match_reg <= in_match_value;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_data_reg   <= cmd.emit_ram ? ram_rdata : '0;
            out_last_reg   <= cmd.emit_last;
        end
    end

    // result beat
    assign res.valid  = out_valid_reg;
    assign res.status = out_status_reg;
    assign res.data   = out_data_reg;
    assign res.last   = out_last_reg;

    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_count_reg <= FILL_W'(STACK_DEPTH),
        "fill count beyond stack depth")
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, cmd.push_wr,
        !sts.full && !cmd.mod_wr, "push written into a full stack")

endmodule

// File: hdl/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// stack controller: decodes commands and sequences reads, walks and results
// ----------------------------------------------------------------------------
module bss_ctrl
    import bss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    `include "assert_macros.svh"

    state_t state_reg, state_next;
    logic   accept;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        accept     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = sts.out_free;
                accept       = in_valid && sts.out_free;
                cmd.load_cmd = accept;
                if (accept)
                begin
                    case (sts.kind) inside
                        KIND_PUSH:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (sts.full)
                            begin
                                cmd.emit_status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push_wr  = 1'b1;
                                cmd.fill_inc = 1'b1;
                            end
                        end
                        KIND_POP, KIND_PEEK, KIND_DISPLAY, KIND_MODIFY:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_last   = 1'b1;
                                cmd.emit_status = STAT_EMPTY;
                            end
                            else if (sts.kind == KIND_MODIFY)
                            begin
                                cmd.rd_en     = 1'b1;
                                cmd.rd_sel    = RD_ZERO;
                                cmd.idx_clear = 1'b1;
                                state_next    = S_SRCH;
                            end
                            else if (sts.kind == KIND_DISPLAY)
                            begin
                                cmd.rd_en        = 1'b1;
                                cmd.rd_sel       = RD_TOP;
                                cmd.idx_load_top = 1'b1;
                                state_next       = S_DISP;
                            end
                            else
                            begin
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = RD_TOP;
                                cmd.fill_dec = (sts.kind == KIND_POP);
                                state_next   = S_READ;
                            end
                        end
                        default:
                        begin
                            // undefined kinds are dropped
                        end
                    endcase
                end
            end

            // single entry for pop or peek
            S_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ram  = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            // display walk, top down, one beat per entry
            S_DISP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ram  = 1'b1;
                    cmd.emit_last = sts.idx_zero;
                    if (sts.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_IDX_DEC;
                        cmd.idx_dec = 1'b1;
                    end
                end
            end

            // modify search, bottom up, one entry per cycle
            S_SRCH:
            begin
                if (sts.hit || sts.idx_top)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.mod_wr      = sts.hit;
                        cmd.emit_status = sts.hit ? STAT_OK : STAT_NOTFOUND;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_IDX_INC;
                    cmd.idx_inc = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.emit, sts.out_free,
        "result loaded over an untaken beat")
    `ASSERT_IMPLIES(a_walk_nonempty, clk, rst_n,
        state_reg == S_DISP || state_reg == S_SRCH, !sts.empty,
        "entry walk on an empty stack")

endmodule

// File: hdl/bounded_stack_with_search_replace.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search_replace
// bounded LIFO stack of signed words with push, pop, peek, display and modify
// ----------------------------------------------------------------------------
//  channel  dir  payload                     handshake
//  cmd      in   kind, value, match_value    valid/ready
//  res      out  status, data, last          valid/ready
//
//  push and the overflow and empty results are emitted from idle on accept;
//  pop and peek first read the top entry; display gives 1 beat per entry;
//  modify scans one entry per cycle through the single RAM read port
//  reset clears fill count, controller state and the result register valid
//  a stalled result beat holds the controller; cmd is taken only in idle
// ----------------------------------------------------------------------------
module bounded_stack_with_search_replace
    import bss_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    bss_cmd_if.sink   cmd,
    bss_res_if.source res
);

    ctrl_cmd_t ctl_cmd;
    dp_sts_t   dp_sts;
    logic      in_ready;

    assign cmd.ready = in_ready;

    // controller
    bss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    // datapath
    bss_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .sts            (dp_sts),
        .in_kind        (cmd.kind),
        .in_value       (cmd.value),
        .in_match_value (cmd.match_value),
        .res            (res)
    );

endmodule
